>>> rtl/assert_macros.svh
// Assertion macros for the RTL intersection pipeline.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ROB_ASSERT(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define ROB_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication failed");
`else
`define ROB_ASSERT(lbl, clk, rst, expr)
`define ROB_ASSERT_IMP(lbl, clk, rst, ante, cons)
`endif
`endif

>>> rtl/rob_pkg.sv
// Package for the ray versus oriented box intersection pipeline.
package rob_pkg;
   localparam int unsigned POS_W      = 24;
   localparam int unsigned DIR_W      = 16;
   localparam int unsigned AXC_W      = 16;
   localparam int unsigned AXIS_W     = 3 * AXC_W;
   localparam int unsigned HALF_W     = 20;
   localparam int unsigned T_W        = 32;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 60;
   localparam int unsigned FRAC_SH    = 14;

   localparam int unsigned P_W     = POS_W + 1;
   localparam int unsigned EP_W    = AXC_W + P_W;
   localparam int unsigned E_W     = EP_W + 2;
   localparam int unsigned FP_W    = AXC_W + DIR_W;
   localparam int unsigned F_W     = FP_W + 2;
   localparam int unsigned HS_W    = HALF_W + FRAC_SH;
   localparam int unsigned NUM_W   = E_W + 1;
   localparam int unsigned D_W     = F_W;
   localparam int unsigned R_W     = D_W + 1;
   localparam int unsigned QW      = T_W + 1;
   localparam int unsigned LOW_W   = QW - FRAC_SH;
   localparam int unsigned DIV_BPS = 3;
   localparam int unsigned DIV_STG = QW / DIV_BPS;
   localparam int unsigned LANES   = 6;

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_U   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_V   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_W   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF     = 3'd6;

   localparam logic [AXIS_W-1:0] AXIS_U_RST = 48'h0000_0000_4000;
   localparam logic [AXIS_W-1:0] AXIS_V_RST = 48'h0000_4000_0000;
   localparam logic [AXIS_W-1:0] AXIS_W_RST = 48'h4000_0000_0000;

   localparam logic signed [T_W-1:0] T_MIN = {1'b1, {(T_W-1){1'b0}}};
   localparam logic signed [T_W-1:0] T_MAX = {1'b0, {(T_W-1){1'b1}}};

   typedef struct packed {
      logic [LANES-1:0] neg;
      logic [LANES-1:0] ovf;
      logic [2:0]       par;
      logic             pmiss;
   } rob_side_type;
endpackage

>>> rtl/ray_oriented_box_intersect.sv
// Ray versus oriented box slab test, fully pipelined.
// One ray is accepted per cycle while the output keeps taking results, and each ray passes
// through 17 register stages (6 + 11); the eleven divider stages each resolve three quotient
// bits for six slab distances in parallel. Stages hold their beat under
// backpressure and empty stages fill, so the rate stays one beat per cycle while the output is ready.
module ray_oriented_box_intersect
   import rob_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
   input  logic [119:0]          req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // hit, t_enter, t_exit, zero pad
   output logic [71:0]           rsp_tdata
);
   localparam int unsigned ST_DIV0 = 4;
   localparam int unsigned ST_SAT  = ST_DIV0 + DIV_STG;
   localparam int unsigned NSTG    = ST_SAT + 2;

   logic signed [POS_W-1:0] center_ff [3];
   logic [AXIS_W-1:0]       axis_ff [3];
   logic [3*HALF_W-1:0]     half_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff[0] <= '0;
         center_ff[1] <= '0;
         center_ff[2] <= '0;
         axis_ff[0]   <= AXIS_U_RST;
         axis_ff[1]   <= AXIS_V_RST;
         axis_ff[2]   <= AXIS_W_RST;
         half_ff      <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CENTER_X: center_ff[0] <= csr_wdata[POS_W-1:0];
            CSR_CENTER_Y: center_ff[1] <= csr_wdata[POS_W-1:0];
            CSR_CENTER_Z: center_ff[2] <= csr_wdata[POS_W-1:0];
            CSR_AXIS_U:   axis_ff[0]   <= csr_wdata[AXIS_W-1:0];
            CSR_AXIS_V:   axis_ff[1]   <= csr_wdata[AXIS_W-1:0];
            CSR_AXIS_W:   axis_ff[2]   <= csr_wdata[AXIS_W-1:0];
            CSR_HALF:     half_ff      <= csr_wdata[3*HALF_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline flow control
   logic [NSTG-1:0] v_ff;
   logic [NSTG-1:0] adv;

   always_comb begin
      adv[NSTG-1] = !v_ff[NSTG-1] || rsp_tready;
      for (int k = NSTG - 2; k >= 0; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) begin
            v_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < NSTG; k++) begin
            if (adv[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   assign req_tready = adv[0];
   assign rsp_tvalid = v_ff[NSTG-1];

   // stage 0: offset from origin to center
   logic signed [P_W-1:0]   p_ff [3];
   logic signed [DIR_W-1:0] d_ff [3];

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         for (int k = 0; k < 3; k++) begin
            p_ff[k] <= P_W'(center_ff[k]) - P_W'($signed(req_tdata[k*POS_W +: POS_W]));
            d_ff[k] <= req_tdata[3*POS_W + k*DIR_W +: DIR_W];
         end
      end
   end

   // stage 1: products
   logic signed [EP_W-1:0] pe_ff [3][3];
   logic signed [FP_W-1:0] pf_ff [3][3];

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         for (int a = 0; a < 3; a++) begin
            for (int k = 0; k < 3; k++) begin
               pe_ff[a][k] <= $signed(axis_ff[a][k*AXC_W +: AXC_W]) * p_ff[k];
               pf_ff[a][k] <= $signed(axis_ff[a][k*AXC_W +: AXC_W]) * d_ff[k];
            end
         end
      end
   end

   // stage 2: projections
   logic signed [E_W-1:0] e_ff [3];
   logic signed [F_W-1:0] f_ff [3];
   logic [HS_W-1:0]       h_ff [3];

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         for (int a = 0; a < 3; a++) begin
            e_ff[a] <= E_W'(pe_ff[a][0]) + E_W'(pe_ff[a][1]) + E_W'(pe_ff[a][2]);
            f_ff[a] <= F_W'(pf_ff[a][0]) + F_W'(pf_ff[a][1]) + F_W'(pf_ff[a][2]);
            h_ff[a] <= {half_ff[a*HALF_W +: HALF_W], {FRAC_SH{1'b0}}};
         end
      end
   end

   // stage 3: divider setup; lane 2a is e+h, lane 2a+1 is e-h
   logic [D_W-1:0]  rem_ff [DIV_STG+1][LANES];
   logic [D_W-1:0]  dvs_ff [DIV_STG+1][LANES];
   logic [QW-1:0]   num_ff [DIV_STG+1][LANES];
   logic [QW-1:0]   quo_ff [DIV_STG+1][LANES];
   rob_side_type    side_ff [DIV_STG+1];

   logic [D_W-1:0]   rem_in [LANES];
   logic [D_W-1:0]   dvs_in [LANES];
   logic [QW-1:0]    num_in [LANES];
   rob_side_type     side_in;

   always_comb begin
      logic signed [NUM_W-1:0] ee;
      logic signed [NUM_W-1:0] hh;
      logic signed [NUM_W-1:0] sn;
      logic [NUM_W-1:0]        mag;
      logic [E_W-1:0]          emag;
      logic [D_W-1:0]          fmag;
      side_in = '0;
      for (int l = 0; l < LANES; l++) begin
         ee   = NUM_W'(e_ff[l/2]);
         hh   = NUM_W'(signed'({1'b0, h_ff[l/2]}));
         sn   = (l % 2 == 0) ? (ee + hh) : (ee - hh);
         mag  = sn[NUM_W-1] ? NUM_W'(-sn) : NUM_W'(sn);
         fmag = f_ff[l/2][F_W-1] ? D_W'(-f_ff[l/2]) : D_W'(f_ff[l/2]);
         rem_in[l]       = D_W'(mag[NUM_W-1:LOW_W]);
         dvs_in[l]       = fmag;
         num_in[l]       = {mag[LOW_W-1:0], {FRAC_SH{1'b0}}};
         side_in.neg[l]  = sn[NUM_W-1] ^ f_ff[l/2][F_W-1];
         side_in.ovf[l]  = D_W'(mag[NUM_W-1:LOW_W]) >= fmag;
      end
      for (int a = 0; a < 3; a++) begin
         emag = e_ff[a][E_W-1] ? E_W'(-e_ff[a]) : E_W'(e_ff[a]);
         side_in.par[a] = (f_ff[a] == '0);
         if ((f_ff[a] == '0) && (emag > E_W'(h_ff[a]))) begin
            side_in.pmiss = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         for (int l = 0; l < LANES; l++) begin
            rem_ff[0][l] <= rem_in[l];
            dvs_ff[0][l] <= dvs_in[l];
            num_ff[0][l] <= num_in[l];
            quo_ff[0][l] <= '0;
         end
         side_ff[0] <= side_in;
      end
   end

   // restoring divider, DIV_BPS quotient bits per stage
   for (genvar s = 0; s < DIV_STG; s++) begin : g_div
      logic [D_W-1:0] r_nx [LANES];
      logic [QW-1:0]  n_nx [LANES];
      logic [QW-1:0]  q_nx [LANES];

      always_comb begin
         logic [R_W-1:0] trial;
         for (int l = 0; l < LANES; l++) begin
            r_nx[l] = rem_ff[s][l];
            n_nx[l] = num_ff[s][l];
            q_nx[l] = quo_ff[s][l];
            for (int b = 0; b < DIV_BPS; b++) begin
               trial   = {r_nx[l], n_nx[l][QW-1]};
               n_nx[l] = {n_nx[l][QW-2:0], 1'b0};
               if (trial >= R_W'(dvs_ff[s][l])) begin
                  r_nx[l] = D_W'(trial - R_W'(dvs_ff[s][l]));
                  q_nx[l] = {q_nx[l][QW-2:0], 1'b1};
               end else begin
                  r_nx[l] = D_W'(trial);
                  q_nx[l] = {q_nx[l][QW-2:0], 1'b0};
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv[ST_DIV0+s]) begin
            for (int l = 0; l < LANES; l++) begin
               rem_ff[s+1][l] <= r_nx[l];
               dvs_ff[s+1][l] <= dvs_ff[s][l];
               num_ff[s+1][l] <= n_nx[l];
               quo_ff[s+1][l] <= q_nx[l];
            end
            side_ff[s+1] <= side_ff[s];
         end
      end
   end

   // sign, saturation and ordering per slab
   localparam logic [QW-1:0] Q_NEG_LIM = QW'(1) << (T_W - 1);

   logic signed [T_W-1:0] lo_ff [3];
   logic signed [T_W-1:0] hi_ff [3];
   logic                  pmiss_ff;

   always_ff @(posedge clock) begin
      logic signed [T_W-1:0] tv [LANES];
      logic [QW-1:0]         q;
      if (adv[ST_SAT]) begin
         for (int l = 0; l < LANES; l++) begin
            q = quo_ff[DIV_STG][l];
            if (side_ff[DIV_STG].neg[l]) begin
               tv[l] = (side_ff[DIV_STG].ovf[l] || q > Q_NEG_LIM) ? T_MIN : T_W'(-q);
            end else begin
               tv[l] = (side_ff[DIV_STG].ovf[l] || q >= Q_NEG_LIM) ? T_MAX : T_W'(q);
            end
         end
         for (int a = 0; a < 3; a++) begin
            if (side_ff[DIV_STG].par[a]) begin
               lo_ff[a] <= T_MIN;
               hi_ff[a] <= T_MAX;
            end else if (tv[2*a] > tv[2*a+1]) begin
               lo_ff[a] <= tv[2*a+1];
               hi_ff[a] <= tv[2*a];
            end else begin
               lo_ff[a] <= tv[2*a];
               hi_ff[a] <= tv[2*a+1];
            end
         end
         pmiss_ff <= side_ff[DIV_STG].pmiss;
      end
   end

   // interval merge and result register
   logic                  hit_ff;
   logic signed [T_W-1:0] tin_ff;
   logic signed [T_W-1:0] tout_ff;

   always_ff @(posedge clock) begin
      logic signed [T_W-1:0] tlo;
      logic signed [T_W-1:0] thi;
      logic                  h;
      if (adv[NSTG-1]) begin
         tlo = lo_ff[0];
         thi = hi_ff[0];
         for (int a = 1; a < 3; a++) begin
            if (lo_ff[a] > tlo) tlo = lo_ff[a];
            if (hi_ff[a] < thi) thi = hi_ff[a];
         end
         h = !pmiss_ff && (tlo <= thi) && !thi[T_W-1];
         hit_ff  <= h;
         tin_ff  <= h ? tlo : '0;
         tout_ff <= h ? thi : '0;
      end
   end

   assign rsp_tdata = {7'b0, tout_ff, tin_ff, hit_ff};

`include "assert_macros.svh"
   `ROB_ASSERT_IMP(a_miss_zero, clock, reset, rsp_tvalid && !rsp_tdata[0], rsp_tdata[64:1] == '0)
   `ROB_ASSERT_IMP(a_hit_order, clock, reset, rsp_tvalid && hit_ff, (tin_ff <= tout_ff) && tout_ff >= 0)
   `ROB_ASSERT_IMP(a_ready_empty, clock, reset, !rsp_tvalid, req_tready)
endmodule

>>> test/tb_top.sv
// Self-checking bench for the ray versus oriented box slab intersection pipeline.
`timescale 1ns / 100ps
module tb_top;
   import rob_pkg::*;

   typedef struct packed {
      logic [2:0][23:0] org;
      logic [2:0][15:0] dir;
   } ray_t;

   typedef struct packed {
      logic        hit;
      logic [31:0] t_enter;
      logic [31:0] t_exit;
   } hit_t;

   typedef struct packed {
      ray_t         ray;
      logic         known;
      logic         hit;
      logic [31:0]  t_enter;
      logic [31:0]  t_exit;
   } row_t;

   localparam int RAND_RAYS = 640;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [119:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;

   logic [23:0] box_ctr [3];
   logic [47:0] box_axis [3];
   logic [59:0] box_half;

   hit_t expected_hits [$];
   int errors = 0;
   int rays_sent = 0;
   int hits_seen = 0;
   int misses_seen = 0;
   int cycles = 0;
   bit stall_long = 0;
   bit stall_done = 0;
   row_t dir_rows [$];

   ray_oriented_box_intersect uut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t timeout", $time);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic logic signed [63:0] sat_t(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic hit_t slab_hit(input ray_t r);
      logic signed [63:0] p [3];
      logic signed [63:0] d [3];
      logic signed [63:0] lo, hi, e, f, h, a, t1, t2, tmp;
      logic ok;
      hit_t res;
      lo = -64'sd2147483648;
      hi = 64'sd2147483647;
      ok = 1'b1;
      for (int k = 0; k < 3; k++) begin
         p[k] = 64'(signed'(box_ctr[k])) - 64'(signed'(r.org[2-k]));
         d[k] = 64'(signed'(r.dir[2-k]));
      end
      for (int i = 0; i < 3; i++) begin
         if (ok) begin
            e = 0;
            f = 0;
            for (int k = 0; k < 3; k++) begin
               a = 64'(signed'(box_axis[i][16*k +: 16]));
               e += a * p[k];
               f += a * d[k];
            end
            h = 64'(box_half[20*i +: 20]) * 64'sd16384;
            if (f != 0) begin
               t1 = sat_t(((e + h) * 64'sd16384) / f);
               t2 = sat_t(((e - h) * 64'sd16384) / f);
               if (t1 > t2) begin
                  tmp = t1; t1 = t2; t2 = tmp;
               end
               if (t1 > lo) lo = t1;
               if (t2 < hi) hi = t2;
               if (lo > hi) ok = 1'b0;
               else if (hi < 0) ok = 1'b0;
            end else if (e > h || -e > h) begin
               ok = 1'b0;
            end
         end
      end
      res.hit = ok;
      res.t_enter = ok ? lo[31:0] : 32'd0;
      res.t_exit = ok ? hi[31:0] : 32'd0;
      return res;
   endfunction

   // fields packed low bit first: origin_x at bit 0
   function automatic logic [119:0] pack_ray(input ray_t r);
      return {r.dir[0], r.dir[1], r.dir[2], r.org[0], r.org[1], r.org[2]};
   endfunction

   function automatic ray_t mk_ray(input logic [23:0] ox, oy, oz,
                                   input logic [15:0] dx, dy, dz);
      ray_t r;
      r.org[2] = ox; r.org[1] = oy; r.org[0] = oz;
      r.dir[2] = dx; r.dir[1] = dy; r.dir[0] = dz;
      return r;
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [59:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_CENTER_X: box_ctr[0] = val[23:0];
         CSR_CENTER_Y: box_ctr[1] = val[23:0];
         CSR_CENTER_Z: box_ctr[2] = val[23:0];
         CSR_AXIS_U:   box_axis[0] = val[47:0];
         CSR_AXIS_V:   box_axis[1] = val[47:0];
         CSR_AXIS_W:   box_axis[2] = val[47:0];
         CSR_HALF:     box_half = val;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_box(input logic [23:0] cx, cy, cz,
                          input logic [47:0] u, v, w, input logic [59:0] hf);
      write_reg(CSR_CENTER_X, 60'(cx));
      write_reg(CSR_CENTER_Y, 60'(cy));
      write_reg(CSR_CENTER_Z, 60'(cz));
      write_reg(CSR_AXIS_U, 60'(u));
      write_reg(CSR_AXIS_V, 60'(v));
      write_reg(CSR_AXIS_W, 60'(w));
      write_reg(CSR_HALF, hf);
   endtask

   task automatic drain();
      while (expected_hits.size() != 0) @(negedge clock);
      repeat (24) @(negedge clock);
   endtask

   // send one ray; leaves inputs ready at a falling edge
   task automatic send_ray(input ray_t r, input bit gaps);
      int gap;
      gap = (gaps && $urandom_range(0, 3) != 0) ? $urandom_range(0, 16) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= pack_ray(r);
      expected_hits.push_back(slab_hit(r));
      do @(posedge clock); while (!req_tready);
      rays_sent++;
      @(negedge clock);
   endtask

   function automatic logic [23:0] rnd_pos(input int mode);
      case (mode)
         0: return 24'($urandom);
         1: return 24'($urandom_range(0, 8191) - 4096);
         default: return 24'($urandom_range(0, 255) - 128);
      endcase
   endfunction

   function automatic logic [15:0] rnd_dir();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'($urandom);
         2: return 16'h8000;
         default: return 16'($urandom_range(0, 32767) - 16384);
      endcase
   endfunction

   function automatic logic [47:0] rnd_axis();
      return {rnd_dir(), rnd_dir(), rnd_dir()};
   endfunction

   // receiver: random stalls, one long hold-off while the sender keeps going
   always @(negedge clock) begin
      int wait_n;
      if (!reset) begin
         if (stall_long && !stall_done) begin
            rsp_tready <= 1'b0;
            repeat (200) @(negedge clock);
            stall_done = 1;
         end
         wait_n = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
         if (wait_n != 0) begin
            rsp_tready <= 1'b0;
            repeat (wait_n) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      hit_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[64:0];
         got.hit = rsp_tdata[0];
         got.t_enter = rsp_tdata[32:1];
         got.t_exit = rsp_tdata[64:33];
         if (expected_hits.size() == 0) begin
            errors++;
            $display("%0t unexpected beat: hit=%0b enter=%h exit=%h", $time,
                     got.hit, got.t_enter, got.t_exit);
         end else begin
            want = expected_hits.pop_front();
            if (got.hit) hits_seen++; else misses_seen++;
            if (got.hit !== want.hit) begin
               errors++;
               $display("%0t hit: expected %0b actual %0b", $time, want.hit, got.hit);
            end
            if (got.t_enter !== want.t_enter) begin
               errors++;
               $display("%0t t_enter: expected %h actual %h", $time, want.t_enter,
                        got.t_enter);
            end
            if (got.t_exit !== want.t_exit) begin
               errors++;
               $display("%0t t_exit: expected %h actual %h", $time, want.t_exit,
                        got.t_exit);
            end
         end
      end
   end

   initial begin
      ray_t r;
      row_t row;
      hit_t pre;
      int mode;
      box_ctr[0] = '0; box_ctr[1] = '0; box_ctr[2] = '0;
      box_axis[0] = AXIS_U_RST; box_axis[1] = AXIS_V_RST; box_axis[2] = AXIS_W_RST;
      box_half = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset box: zero size at origin; a ray from origin with nonzero direction hits at t=0
      row = '{mk_ray(0, 0, 0, 16'h4000, 16'h4000, 16'h4000), 1, 1, 0, 0};
      dir_rows.push_back(row);
      row = '{mk_ray(0, 0, 0, 0, 0, 0), 1, 1, 32'h8000_0000, 32'h7fff_ffff};
      dir_rows.push_back(row);
      row = '{mk_ray(24'h100, 0, 0, 0, 0, 0), 1, 0, 0, 0};
      dir_rows.push_back(row);
      row = '{mk_ray(24'h800000, 24'h7fffff, 24'h800000, 16'h8000, 16'h7fff,
                     16'h8000), 1, 0, 0, 0};
      dir_rows.push_back(row);
      row = '{mk_ray(24'h7fffff, 0, 0, 16'h0001, 0, 0), 1, 0, 0, 0};
      dir_rows.push_back(row);
      foreach (dir_rows[i]) begin
         r = dir_rows[i].ray;
         pre = slab_hit(r);
         if (dir_rows[i].known && pre !== hit_t'({dir_rows[i].hit, dir_rows[i].t_enter,
                                                 dir_rows[i].t_exit})) begin
            errors++;
            $display("%0t table row %0d: expected %h actual %h", $time, i,
                     {dir_rows[i].hit, dir_rows[i].t_enter, dir_rows[i].t_exit}, pre);
         end
         send_ray(r, 0);
      end
      req_tvalid <= 1'b0;
      drain();

      // unit box at origin, axis aligned, directed rays
      set_box(0, 0, 0, AXIS_U_RST, AXIS_V_RST, AXIS_W_RST,
              {20'h100, 20'h100, 20'h100});
      send_ray(mk_ray(24'hfffc00, 0, 0, 16'h4000, 0, 0), 0);
      send_ray(mk_ray(24'h000400, 0, 0, 16'h4000, 0, 0), 0);
      send_ray(mk_ray(0, 0, 0, 16'hc000, 16'h2000, 16'h0001), 0);
      send_ray(mk_ray(0, 24'h000200, 0, 16'h4000, 0, 0), 0);
      send_ray(mk_ray(0, 24'h000100, 0, 16'h4000, 0, 0), 0);
      send_ray(mk_ray(24'hfffc00, 24'hfffc00, 24'hfffc00, 16'h7fff, 16'h7fff, 16'h7fff), 0);
      send_ray(mk_ray(0, 0, 0, 16'h0001, 16'h0001, 16'h0001), 0);
      req_tvalid <= 1'b0;
      drain();

      // extreme box: full-scale fields, negated axes
      set_box(24'h7fffff, 24'h800000, 24'h7fffff, 48'h8000_8000_8000, 48'h7fff_0000_8000,
              48'h0000_7fff_7fff, 60'hfff_ffff_ffff_ffff);
      send_ray(mk_ray(24'h800000, 24'h7fffff, 24'h800000, 16'h0001, 16'hffff, 16'h8000), 0);
      send_ray(mk_ray(0, 0, 0, 16'h7fff, 16'h8000, 16'h0001), 0);
      send_ray(mk_ray(24'h7fffff, 24'h800000, 24'h7fffff, 0, 0, 0), 0);
      req_tvalid <= 1'b0;
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         if (phase == 3)
            set_box(rnd_pos(0), rnd_pos(0), rnd_pos(0), rnd_axis(), rnd_axis(), rnd_axis(),
                    60'({$urandom, $urandom}));
         else
            set_box(rnd_pos(1), rnd_pos(2), rnd_pos(1),
                    phase == 0 ? AXIS_U_RST : rnd_axis(),
                    phase == 0 ? AXIS_V_RST : rnd_axis(),
                    phase == 0 ? AXIS_W_RST : rnd_axis(),
                    {20'($urandom_range(1, 4095)), 20'($urandom_range(1, 4095)),
                     20'($urandom_range(1, 4095))});
         for (int n = 0; n < RAND_RAYS / 4; n++) begin
            if (phase == 1 && n == 20) stall_long = 1;
            mode = (phase == 3) ? 0 : $urandom_range(0, 2);
            r = mk_ray(rnd_pos(mode), rnd_pos(mode), rnd_pos(mode),
                       rnd_dir(), rnd_dir(), rnd_dir());
            send_ray(r, n % 80 >= 20);
            if (n == 100) begin
               req_tvalid <= 1'b0;
               while (expected_hits.size() != 0) @(negedge clock);
            end
         end
         req_tvalid <= 1'b0;
         drain();
      end

      $display("covered %0d rays over 7 box settings: %0d hits, %0d misses",
               rays_sent, hits_seen, misses_seen);
      if (errors == 0 && expected_hits.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
